FILE: src/rolling_zscore_fade_signal_unit_macros.svh
// Assertion macros for the rolling z-score fade unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ROLLING_ZSCORE_FADE_SIGNAL_UNIT_MACROS_SVH
`define ROLLING_ZSCORE_FADE_SIGNAL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define RZS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define RZS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define RZS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RZS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define RZS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define RZS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/rzs_pkg.sv
// Shared types, constants and helpers of the rolling z-score fade unit.
// No dependencies; used by the channel interfaces, the serial multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rzs_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 22;

  // Fixed field widths.
  localparam int WIN_LEN_W  = 9;
  localparam int THR_W      = 8;
  localparam int PSIGN_W    = 2;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_SIGN   = 2'd2;

  // Register reset values.
  localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST  = 9'd52;
  localparam logic [THR_W-1:0]     Z_THRESHOLD_RST = 8'd24;
  localparam logic [PSIGN_W-1:0]   PAIR_SIGN_RST   = 2'b01;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_FLAT  = 2'b00;
  localparam logic [DIR_W-1:0] DIR_LONG  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_SHORT = 2'b11;

  // The threshold is Q4.4, so its square carries a scale of 2^8.
  localparam int LHS_SHIFT = 2 * 4;

  // Multiplier digit processed per cycle by the serial multiplier.
  localparam int DIGIT_W = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Contrarian direction. With flip set the result is the negated pair sign.
  // Both encodings of a negative pair sign count as -1.
  function automatic logic [DIR_W-1:0] fade_dir(input logic [PSIGN_W-1:0] ps,
                                                input logic flip);
    logic [DIR_W-1:0] r;
    case (ps) inside
      2'b00:        r = DIR_FLAT;
      2'b01:        r = flip ? DIR_SHORT : DIR_LONG;
      2'b10, 2'b11: r = flip ? DIR_LONG : DIR_SHORT;
      default:      r = DIR_FLAT;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/rzs_channels.sv
// Valid/ready channel interfaces of the rolling z-score fade unit: samples, results, config.
// Depends on rzs_pkg for the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none
interface rzs_in_if #(
  parameter int SAMPLE_BITS = rzs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] net_position;

  modport source (output valid, output net_position, input ready);
  modport sink   (input valid, input net_position, output ready);
endinterface

interface rzs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rzs_pkg::DIR_W-1:0] direction;
  logic                             window_ready;

  modport source (output valid, output direction, output window_ready, input ready);
  modport sink   (input valid, input direction, input window_ready, output ready);
endinterface

interface rzs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rzs_pkg::CFG_IDX_W-1:0]     index;
  logic [rzs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/rzs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/rzs_serial_mul.sv
// Serial-parallel unsigned multiplier: one multiplier digit per cycle, shift-add.
// Depends on rzs_pkg (digit width, status struct) and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_zscore_fade_signal_unit_macros.svh"
module rzs_serial_mul #(
  parameter int P_W = 64,
  parameter int B_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [P_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output rzs_pkg::mul_stat_t      stat,
  output logic      [P_W-1:0]     prod
);
  import rzs_pkg::*;

  logic [P_W-1:0] a_r, a_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic [P_W-1:0] acc_r, acc_nxt;
  logic           busy_r, busy_nxt;
  logic [P_W-1:0] part;
  logic           b_empty;

  assign b_empty = (b_r == '0);

  // Partial product of the multiplicand and the low digit, as a short shift-add.
  always_comb begin
    part = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (b_r[i]) begin
        part = part + (a_r << i);
      end
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_empty) begin
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = acc_r + part;
        a_nxt   = a_r << DIGIT_W;
        b_nxt   = b_r >> DIGIT_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && b_empty;
  assign prod      = acc_r;

  `RZS_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_r, "multiplier not busy after start")

endmodule
`default_nettype wire

FILE: src/rolling_zscore_fade_signal_unit.sv
// Top level of the rolling z-score fade unit: sample ring, running sums and decision sequencer.
// Depends on rzs_pkg, rzs_channels, rzs_ram, rzs_serial_mul and the assertion macro header.
//
// Channel  Dir   Payload                              Beat
// in_ch    sink  net_position[SAMPLE_BITS], signed    one position sample
// out_ch   src   direction[2] signed, window_ready    one decision per sample
// cfg_ch   sink  index[2], data[9]                    one register write
//
// A sample is taken in IDLE, the ring and sum are updated in READ, and then one shared
// 4-bit-digit multiplier runs the products in turn. Until the window holds one sample
// more than its length only the square update runs; after that nine products run.
// Reset (synchronous, rst_n low) restores the registers and empties the history; the ring
// itself is not cleared. A result waits in the output register while the next sample is
// taken; the sequencer stalls at its last state only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_zscore_fade_signal_unit_macros.svh"
module rolling_zscore_fade_signal_unit #(
  parameter int MAX_WINDOW  = rzs_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = rzs_pkg::SAMPLE_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rzs_in_if.sink     in_ch,
  rzs_out_if.source  out_ch,
  rzs_cfg_if.sink    cfg_ch
);
  import rzs_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int EW    = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W = SB + EW;
  localparam int SQ_W  = 2 * SB - 2 + EW;
  localparam int T_W   = 2 * SUM_W;
  localparam int P_W   = T_W + 2 * THR_W + EW;
  localparam int B_W   = EW + ((SB > 2 * THR_W) ? SB : 2 * THR_W);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_SQ   = 4'd2;
  localparam logic [3:0] ST_D    = 4'd3;
  localparam logic [3:0] ST_WQ   = 4'd4;
  localparam logic [3:0] ST_SS   = 4'd5;
  localparam logic [3:0] ST_DD   = 4'd6;
  localparam logic [3:0] ST_LHS  = 4'd7;
  localparam logic [3:0] ST_TH   = 4'd8;
  localparam logic [3:0] ST_THW  = 4'd9;
  localparam logic [3:0] ST_RHS  = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;

  // Control state.
  logic [3:0]            state_r, state_nxt;
  logic [WIN_LEN_W-1:0]  window_len_r, window_len_nxt;
  logic [THR_W-1:0]      thr_r, thr_nxt;
  logic [PSIGN_W-1:0]    psign_r, psign_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SQ_W-1:0]       sumsq_r, sumsq_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic [SB-1:0]         x_r, x_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  sq_neg_r, sq_neg_nxt;
  logic                  d_neg_r, d_neg_nxt;
  logic                  d_zero_r, d_zero_nxt;
  logic [SUM_W-1:0]      ad_r, ad_nxt;
  logic [T_W-1:0]        t_r, t_nxt;
  logic [P_W-1:0]        lhs_r, lhs_nxt;
  logic [DIR_W-1:0]      dir_r, dir_nxt;
  logic [DIR_W-1:0]      out_dir_r, out_dir_nxt;
  logic                  out_win_r, out_win_nxt;

  // Ring memory and multiplier connections.
  logic                  ram_we, ram_re;
  logic [SB-1:0]         ram_rdata;
  logic                  mul_start;
  logic [P_W-1:0]        mul_a;
  logic [B_W-1:0]        mul_b;
  mul_stat_t             mul_stat;
  logic [P_W-1:0]        mul_prod;

  // Derived values.
  logic [31:0]           wl32;
  logic [EW-1:0]         w_eff, w_m1;
  logic [CNT_W-1:0]      w_cnt, w_plus1, cnt_inc;
  logic                  ring_full;
  logic [EW-1:0]         wp_inc;
  logic [SB-1:0]         old_s;
  logic [SB:0]           sp, sm, sp_neg, sm_neg, sp_mag, sm_mag;
  logic [SB-1:0]         x_neg, x_mag;
  logic [SUM_W-1:0]      x_ext, old_ext, sum_neg, sum_mag;
  logic [SUM_W:0]        wx_pos, wx, d_val, d_negv;
  logic [SUM_W-1:0]      d_mag;
  logic                  hit;

  // Effective window: the register clamped to [2, MAX_WINDOW].
  assign wl32  = 32'(window_len_r);
  assign w_eff = (wl32 < 32'd2) ? EW'(2) :
                 (wl32 > 32'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : EW'(wl32);
  assign w_m1  = w_eff - 1'b1;

  assign w_cnt     = CNT_W'(w_eff);
  assign w_plus1   = w_cnt + 1'b1;
  assign ring_full = (cnt_r >= w_cnt);
  assign cnt_inc   = (cnt_r < w_plus1) ? cnt_r + 1'b1 : cnt_r;
  assign wp_inc    = EW'(wp_r) + 1'b1;

  // The sample leaving the window counts as zero until the ring has filled.
  assign old_s = ring_full ? ram_rdata : '0;

  // x*x - old*old is formed as (x + old) * (x - old) in one product.
  assign sp     = {x_r[SB-1], x_r} + {old_s[SB-1], old_s};
  assign sm     = {x_r[SB-1], x_r} - {old_s[SB-1], old_s};
  assign sp_neg = ~sp + 1'b1;
  assign sm_neg = ~sm + 1'b1;
  assign sp_mag = sp[SB] ? sp_neg : sp;
  assign sm_mag = sm[SB] ? sm_neg : sm;

  assign x_neg   = ~x_r + 1'b1;
  assign x_mag   = x_r[SB-1] ? x_neg : x_r;
  assign x_ext   = {{EW{x_r[SB-1]}}, x_r};
  assign old_ext = {{EW{old_s[SB-1]}}, old_s};
  assign sum_neg = ~sum_r + 1'b1;
  assign sum_mag = sum_r[SUM_W-1] ? sum_neg : sum_r;

  // D = W*x - S, with W*|x| coming from the multiplier.
  assign wx_pos = {1'b0, mul_prod[SUM_W-1:0]};
  assign wx     = x_r[SB-1] ? (~wx_pos + 1'b1) : wx_pos;
  assign d_val  = wx - {sum_r[SUM_W-1], sum_r};
  assign d_negv = ~d_val + 1'b1;
  assign d_mag  = d_val[SUM_W] ? d_negv[SUM_W-1:0] : d_val[SUM_W-1:0];

  assign hit = (t_r != '0) && (lhs_r >= mul_prod);

  always_comb begin
    state_nxt      = state_r;
    window_len_nxt = window_len_r;
    thr_nxt        = thr_r;
    psign_nxt      = psign_r;
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    sumsq_nxt      = sumsq_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    rdy_nxt        = rdy_r;
    sq_neg_nxt     = sq_neg_r;
    d_neg_nxt      = d_neg_r;
    d_zero_nxt     = d_zero_r;
    ad_nxt         = ad_r;
    t_nxt          = t_r;
    lhs_nxt        = lhs_r;
    dir_nxt        = dir_r;
    out_dir_nxt    = out_dir_r;
    out_win_nxt    = out_win_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.net_position;
          ram_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_we     = 1'b1;
        sum_nxt    = sum_r + x_ext - old_ext;
        sq_neg_nxt = sp[SB] ^ sm[SB];
        mul_start  = 1'b1;
        mul_a      = P_W'(sp_mag);
        mul_b      = B_W'(sm_mag);
        wp_nxt     = (wp_inc >= w_eff) ? '0 : PTR_W'(wp_inc);
        cnt_nxt    = cnt_inc;
        rdy_nxt    = (cnt_inc >= w_plus1);
        state_nxt  = ST_SQ;
      end
      ST_SQ: begin
        if (mul_stat.done) begin
          sumsq_nxt = sq_neg_r ? sumsq_r - mul_prod[SQ_W-1:0]
                               : sumsq_r + mul_prod[SQ_W-1:0];
          if (rdy_r) begin
            mul_start = 1'b1;
            mul_a     = P_W'(x_mag);
            mul_b     = B_W'(w_eff);
            state_nxt = ST_D;
          end else begin
            dir_nxt   = DIR_FLAT;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_D: begin
        if (mul_stat.done) begin
          d_neg_nxt  = d_val[SUM_W];
          d_zero_nxt = (d_val == '0);
          ad_nxt     = d_mag;
          mul_start  = 1'b1;
          mul_a      = P_W'(sumsq_r);
          mul_b      = B_W'(w_eff);
          state_nxt  = ST_WQ;
        end
      end
      ST_WQ: begin
        if (mul_stat.done) begin
          t_nxt     = mul_prod[T_W-1:0];
          mul_start = 1'b1;
          mul_a     = P_W'(sum_mag);
          mul_b     = B_W'(sum_mag);
          state_nxt = ST_SS;
        end
      end
      ST_SS: begin
        if (mul_stat.done) begin
          t_nxt     = t_r - mul_prod[T_W-1:0];
          mul_start = 1'b1;
          mul_a     = P_W'(ad_r);
          mul_b     = B_W'(ad_r);
          state_nxt = ST_DD;
        end
      end
      ST_DD: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = B_W'(w_m1);
          state_nxt = ST_LHS;
        end
      end
      ST_LHS: begin
        if (mul_stat.done) begin
          lhs_nxt   = mul_prod << LHS_SHIFT;
          mul_start = 1'b1;
          mul_a     = P_W'(thr_r);
          mul_b     = B_W'(thr_r);
          state_nxt = ST_TH;
        end
      end
      ST_TH: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = B_W'(w_eff);
          state_nxt = ST_THW;
        end
      end
      ST_THW: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = P_W'(t_r);
          mul_b     = B_W'(mul_prod);
          state_nxt = ST_RHS;
        end
      end
      ST_RHS: begin
        if (mul_stat.done) begin
          // A zero deviation counts as negative, so it gives the pair sign itself.
          dir_nxt   = hit ? fade_dir(psign_r, !d_neg_r && !d_zero_r) : DIR_FLAT;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = dir_r;
          out_win_nxt   = rdy_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes must arrive only while the unit is idle; the block does not enforce it.
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WINDOW_LEN: begin
          window_len_nxt = cfg_ch.data;
          wp_nxt         = '0;
          cnt_nxt        = '0;
          sum_nxt        = '0;
          sumsq_nxt      = '0;
        end
        REG_Z_THRESHOLD: begin
          thr_nxt = cfg_ch.data[THR_W-1:0];
        end
        REG_PAIR_SIGN: begin
          psign_nxt = cfg_ch.data[PSIGN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= WINDOW_LEN_RST;
      thr_r        <= Z_THRESHOLD_RST;
      psign_r      <= PAIR_SIGN_RST;
      wp_r         <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      sumsq_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      window_len_r <= window_len_nxt;
      thr_r        <= thr_nxt;
      psign_r      <= psign_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      sumsq_r      <= sumsq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    rdy_r     <= rdy_nxt;
    sq_neg_r  <= sq_neg_nxt;
    d_neg_r   <= d_neg_nxt;
    d_zero_r  <= d_zero_nxt;
    ad_r      <= ad_nxt;
    t_r       <= t_nxt;
    lhs_r     <= lhs_nxt;
    dir_r     <= dir_nxt;
    out_dir_r <= out_dir_nxt;
    out_win_r <= out_win_nxt;
  end

  rzs_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (x_r),
    .re    (ram_re),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  rzs_serial_mul #(
    .P_W (P_W),
    .B_W (B_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.direction    = out_dir_r;
  assign out_ch.window_ready = out_win_r;

  `RZS_ASSERT_ALWAYS(a_ptr_in_window, clk, rst_n, EW'(wp_r) < w_eff, "write pointer outside window")
  `RZS_ASSERT_ALWAYS(a_count_saturates, clk, rst_n, cnt_r <= w_plus1, "sample count beyond window plus one")
  `RZS_ASSERT_IMPLIES(a_idle_mul_quiet, clk, rst_n, state_r == ST_IDLE, !mul_stat.busy, "multiplier busy while idle")

endmodule
`default_nettype wire

FILE: tb/tb_rolling_zscore_fade_signal_unit.sv
// Testbench for the rolling z-score fade unit: directed and random position samples,
// register changes between phases, and a scoreboard that predicts every decision beat.
// Depends on rzs_pkg, the rzs channel interfaces and the rolling_zscore_fade_signal_unit RTL.
`timescale 1ns / 1ps
module tb_rolling_zscore_fade_signal_unit;
  import rzs_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int NUM_SAMPLES = 1950;
  localparam logic signed [SB-1:0] SMP_MAX = 22'h1FFFFF;
  localparam logic signed [SB-1:0] SMP_MIN = 22'h200000;
  localparam int SMP_HI = 2097151;
  localparam int SMP_LO = -2097152;

  // Pair sign encodings; both patterns with the top bit set mean a quote currency.
  localparam logic [PSIGN_W-1:0] PS_NONE      = 2'b00;
  localparam logic [PSIGN_W-1:0] PS_BASE      = 2'b01;
  localparam logic [PSIGN_W-1:0] PS_QUOTE_ALT = 2'b10;
  localparam logic [PSIGN_W-1:0] PS_QUOTE     = 2'b11;

  typedef enum int {
    MIX_UNIFORM,
    MIX_TINY,
    MIX_EXTREME,
    MIX_SPIKY,
    MIX_SCALED
  } mix_t;

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic             window_ready;
  } decision_t;

  class fade_scoreboard;
    logic signed [SB-1:0] ring [MAX_WINDOW_DEF];
    int unsigned          wp;
    int unsigned          seen;
    longint               sum;
    longint               sumsq;
    logic [WIN_LEN_W-1:0] win;
    logic [THR_W-1:0]     thr;
    logic [PSIGN_W-1:0]   ps;
    decision_t            decisions_due[$];
    int                   errors;
    int                   results;

    function new();
      win = WINDOW_LEN_RST;
      thr = Z_THRESHOLD_RST;
      ps = PAIR_SIGN_RST;
      errors = 0;
      results = 0;
      restart();
    endfunction

    function void restart();
      wp = 0;
      seen = 0;
      sum = 0;
      sumsq = 0;
    endfunction

    function int unsigned eff_window();
      if (win < 2) return 2;
      if (win > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return win;
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_LEN: begin
          win = data;
          restart();
        end
        REG_Z_THRESHOLD: thr = data[THR_W-1:0];
        REG_PAIR_SIGN: ps = data[PSIGN_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact threshold test: 256*(W-1)*D^2 >= t^2*W*T with D = W*x - S, T = W*Q - S^2.
    function void note_sample(input logic signed [SB-1:0] x);
      int unsigned w;
      longint      xl;
      longint      old;
      longint      d;
      longint      t;
      longint      ad;
      logic [127:0] mag;
      logic [127:0] scale;
      logic [127:0] lhs;
      logic [127:0] rhs;
      decision_t   e;
      w = eff_window();
      xl = x;
      if (seen >= w) begin
        old = ring[wp];
        sum -= old;
        sumsq -= old * old;
      end
      ring[wp] = x;
      sum += xl;
      sumsq += xl * xl;
      wp = (wp + 1 >= w) ? 0 : wp + 1;
      if (seen < w + 1) seen++;
      e.window_ready = (seen >= w + 1);
      e.direction = DIR_FLAT;
      if (e.window_ready) begin
        d = longint'(w) * xl - sum;
        t = longint'(w) * sumsq - sum * sum;
        if (t != 0) begin
          ad = (d < 0) ? -d : d;
          mag = ad;
          scale = 128'(256 * (w - 1));
          lhs = mag * mag * scale;
          mag = t;
          scale = 128'(thr) * 128'(thr) * 128'(w);
          rhs = mag * scale;
          if (lhs >= rhs && ps != PS_NONE) begin
            // A zero z counts as negative, so only a strictly positive D flips.
            e.direction = ((d > 0) ^ ps[1]) ? DIR_SHORT : DIR_LONG;
          end
        end
      end
      decisions_due = {decisions_due, e};
    endfunction

    task report_mismatch(input string what, input logic [DIR_W-1:0] got,
                         input logic [DIR_W-1:0] want);
      errors++;
      $display("MISMATCH decision %0d: %s got %b, predicted %b", results, what, got, want);
    endtask

    task check_decision(input logic [DIR_W-1:0] dir, input logic rdy);
      decision_t e;
      results++;
      if (decisions_due.size() == 0) begin
        errors++;
        $display("MISMATCH decision %0d: beat with no sample outstanding", results);
      end else begin
        e = decisions_due.pop_front();
        if (dir !== e.direction) report_mismatch("direction", dir, e.direction);
        if (rdy !== e.window_ready)
          report_mismatch("window_ready", {1'b0, rdy}, {1'b0, e.window_ready});
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int   items_sent = 0;
  fade_scoreboard sb = new();

  rzs_in_if #(.SAMPLE_BITS(SB)) in_if();
  rzs_out_if out_if();
  rzs_cfg_if cfg_if();

  rolling_zscore_fade_signal_unit #(
    .MAX_WINDOW(MAX_WINDOW_DEF),
    .SAMPLE_BITS(SB)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_decision(out_if.direction, out_if.window_ready);
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_sample(input logic signed [SB-1:0] v);
    int gap;
    if (!steady && $urandom_range(99) < 15) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.net_position <= v;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Writes the chosen registers back to back; valid stays high between writes.
  task automatic set_regs(input bit do_win, input logic [WIN_LEN_W-1:0] win,
                          input bit do_thr, input logic [THR_W-1:0] thr,
                          input bit do_ps, input logic [PSIGN_W-1:0] ps);
    logic [CFG_IDX_W-1:0]  idx_q[$];
    logic [CFG_DATA_W-1:0] data_q[$];
    if (do_win) begin
      idx_q = {idx_q, REG_WINDOW_LEN};
      data_q = {data_q, win};
    end
    if (do_thr) begin
      idx_q = {idx_q, REG_Z_THRESHOLD};
      data_q = {data_q, CFG_DATA_W'(thr)};
    end
    if (do_ps) begin
      idx_q = {idx_q, REG_PAIR_SIGN};
      data_q = {data_q, CFG_DATA_W'(ps)};
    end
    foreach (idx_q[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx_q[i];
      cfg_if.data <= data_q[i];
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx_q[i], data_q[i]);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // The sender holds off until every decision has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] pick_sample(input mix_t mix, input int base);
    logic [31:0] r;
    int          v;
    r = $urandom();
    case (mix)
      MIX_TINY: return SB'(int'($urandom_range(6)) - 3);
      MIX_EXTREME: begin
        case ($urandom_range(4))
          0: return SMP_MAX;
          1: return SMP_MIN;
          2: return '0;
          3: return -22'sd1;
          default: return 22'sd1;
        endcase
      end
      MIX_SPIKY: begin
        // A calm level with the odd large excursion.
        if ($urandom_range(99) < 12) return r[SB-1:0];
        v = base + int'($urandom_range(8)) - 4;
        if (v > SMP_HI) v = SMP_HI;
        if (v < SMP_LO) v = SMP_LO;
        return SB'(v);
      end
      MIX_SCALED: return $signed(r[SB-1:0]) >>> $urandom_range(SB - 1);
      default: return r[SB-1:0];
    endcase
  endfunction

  function automatic logic [WIN_LEN_W-1:0] pick_window();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(2, 8);
    if (r < 75) return $urandom_range(9, 24);
    if (r < 85) return $urandom_range(25, 64);
    if (r < 89) return $urandom_range(1);
    if (r < 93) return MAX_WINDOW_DEF;
    return $urandom_range(MAX_WINDOW_DEF + 1, 511);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return 8'd255;
    if (r < 40) return $urandom_range(255);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PSIGN_W-1:0] pick_pair_sign();
    int r;
    r = $urandom_range(99);
    if (r < 10) return PS_NONE;
    if (r < 50) return PS_BASE;
    if (r < 85) return PS_QUOTE;
    return PS_QUOTE_ALT;
  endfunction

  initial begin
    bit   first;
    bit   do_win;
    int   n;
    int   base;
    mix_t mix;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.net_position = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Window of zero clamps to two: full-scale swings, then a flat window.
    set_regs(1, 9'd0, 1, 8'd24, 1, PS_BASE);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(22'sd5);
    send_sample(22'sd5);
    send_sample(22'sd5);
    drain();

    // Zero threshold: the newest sample sits on the mean, so z is zero.
    set_regs(1, 9'd3, 1, 8'd0, 1, PS_QUOTE_ALT);
    send_sample(-22'sd1);
    send_sample(22'sd1);
    send_sample(22'sd5);
    send_sample(-22'sd1);
    send_sample(22'sd1);
    send_sample(22'sd0);
    drain();

    // Largest threshold after a constant run, then a flat pair sign.
    set_regs(1, 9'd4, 1, 8'd255, 1, PS_QUOTE);
    repeat (4) send_sample(22'sd0);
    send_sample(SMP_MAX);
    drain();
    set_regs(0, '0, 1, 8'd16, 1, PS_NONE);
    send_sample(SMP_MIN);
    send_sample(22'sd7);
    drain();

    first = 1'b1;
    while (items_sent < NUM_SAMPLES) begin
      steady = (items_sent >= 800 && items_sent < 1100);
      do_win = first || ($urandom_range(99) < 70);
      set_regs(do_win, pick_window(), first || ($urandom_range(99) < 60), pick_threshold(),
               first || ($urandom_range(99) < 60), pick_pair_sign());
      first = 1'b0;
      n = (sb.eff_window() > 64) ? $urandom_range(5, 20) : $urandom_range(8, 50);
      if (do_win) n += sb.eff_window() + 1;
      mix = mix_t'($urandom_range(4));
      base = $signed(pick_sample(MIX_UNIFORM, 0));
      repeat (n) send_sample(pick_sample(mix, base));
      drain();
    end
    steady = 1'b0;

    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
